### rtl/ieval_pkg.sv
// shared types and constants of the infix expression evaluator
// no dependencies; imported by every other file of the block except ieval_muldiv
`default_nettype none

package ieval_pkg;

    localparam int CHAR_WIDTH   = 8;
    localparam int RESULT_WIDTH = 32;

    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

    // multiplicative operator waiting for its right operand
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_MUL,
        MUL_DIV
    } ieval_mulop_t;

    // datapath action per cycle
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CHAR,
        ACT_APPLY,
        ACT_START,
        ACT_FINAL
    } ieval_act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_OPWAIT,
        ST_TAIL,
        ST_TAILWAIT,
        ST_EMIT
    } ieval_state_t;

    typedef struct packed {
        logic       load_char;
        ieval_act_t act;
    } ieval_cmd_t;

    typedef struct packed {
        logic is_op;
        logic last;
        logic pend_none;
        logic unit_busy;
        logic out_free;
    } ieval_status_t;

endpackage

`default_nettype wire

### rtl/infix_integer_expression_eval.sv
// top level of the streaming infix integer expression evaluator
// depends on ieval_pkg, ieval_ctrl, ieval_dp (which holds ieval_muldiv)
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid s_tready   s_tdata[7:0] char_code, s_tlast last_char
//  m_       out  m_tvalid m_tready   m_tdata[31:0] result_value, m_tuser[0] div_zero_error
//
// a character that is not an operator, or an operator with no * or / waiting, passes
// through IDLE and DECODE; an operator that closes a waiting * or / also waits in OPWAIT
// for the bit-serial multiply / divide unit
// after the last character, TAIL starts any waiting * or / and TAILWAIT waits for it;
// EMIT then loads the result register and m_tvalid together once the output is free
// synchronous active-low reset clears the expression state; no clearing pass
// an untaken result holds off only the next result write, and s_tready with it
`default_nettype none

module infix_integer_expression_eval #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [ieval_pkg::CHAR_WIDTH-1:0]      s_tdata,   // [7:0] char_code
    input  wire logic                                  s_tlast,   // last_char
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [ieval_pkg::RESULT_WIDTH-1:0]         m_tdata,   // [31:0] result_value
    output logic                                       m_tuser    // [0] div_zero_error
);

    import ieval_pkg::*;

    ieval_cmd_t    cmd;
    ieval_status_t status;

    // controller: one transaction at a time, sequences the datapath
    ieval_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: running sum, product term, digit accumulator, result register
    ieval_dp #(
        .W (VALUE_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_value (m_tdata),
        .out_err   (m_tuser)
    );

endmodule

`default_nettype wire

### rtl/ieval_muldiv.sv
// iterative multiply / signed divide unit, one bit per cycle
// depends on nothing; used by the datapath
`default_nettype none

module ieval_muldiv #(
    parameter int W = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic         is_div,
    input  wire logic [W-1:0] op_a,
    input  wire logic [W-1:0] op_b,
    output logic              busy,
    output logic [W-1:0]      result
);

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          fin_reg;
    logic          div_reg;
    logic          neg_reg;
    logic          zero_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  res_reg;

    logic [W:0]    rem_sh;
    logic [W:0]    rem_diff;
    logic          qbit;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;

    assign rem_sh   = {acc_reg, a_reg[W-1]};
    assign rem_diff = rem_sh - {1'b0, b_reg};
    assign qbit     = ~rem_diff[W];
    assign mag_a    = op_a[W-1] ? (W'(0) - op_a) : op_a;
    assign mag_b    = op_b[W-1] ? (W'(0) - op_b) : op_b;

    assign busy   = busy_reg | fin_reg;
    assign result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end else if (fin_reg) begin
            fin_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= is_div;
            cnt_reg <= CW'(W - 1);
            acc_reg <= '0;
            if (is_div) begin
                a_reg    <= mag_a;
                b_reg    <= mag_b;
                neg_reg  <= op_a[W-1] ^ op_b[W-1];
                zero_reg <= (op_b == '0);
            end else begin
                a_reg    <= op_a;
                b_reg    <= op_b;
                neg_reg  <= 1'b0;
                zero_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (div_reg) begin
                // restoring step: remainder in acc, quotient shifts into a
                acc_reg <= qbit ? rem_diff[W-1:0] : rem_sh[W-1:0];
                a_reg   <= {a_reg[W-2:0], qbit};
            end else begin
                // shift-add, low half of the product only
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= {a_reg[W-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[W-1:1]};
            end
        end else if (fin_reg) begin
            if (!div_reg) begin
                res_reg <= acc_reg;
            end else if (zero_reg) begin
                res_reg <= '0;
            end else begin
                res_reg <= neg_reg ? (W'(0) - a_reg) : a_reg;
            end
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg && !fin_reg)
        else $error("muldiv started while busy");

    a_phase_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && fin_reg))
        else $error("muldiv iterate and finish phases overlap");

endmodule

`default_nettype wire

### rtl/ieval_dp.sv
// datapath: expression state registers, digit accumulator, result register
// depends on ieval_pkg and ieval_muldiv
`default_nettype none

module ieval_dp #(
    parameter int W = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [ieval_pkg::CHAR_WIDTH-1:0]    in_char,
    input  wire logic                                in_last,
    input  wire ieval_pkg::ieval_cmd_t               cmd,
    output ieval_pkg::ieval_status_t                 status,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [ieval_pkg::RESULT_WIDTH-1:0]       out_value,
    output logic                                     out_err
);

    import ieval_pkg::*;

    logic [CHAR_WIDTH-1:0]   char_reg;
    logic                    last_reg;
    logic [W-1:0]            sum_reg;
    logic [W-1:0]            prod_reg;
    logic [W-1:0]            cur_reg;
    logic                    sign_reg;
    ieval_mulop_t            pend_reg;
    logic                    stopped_reg;
    logic                    derr_reg;
    logic                    out_valid_reg;
    logic [RESULT_WIDTH-1:0] out_value_reg;
    logic                    out_err_reg;

    logic                    is_space;
    logic                    is_star;
    logic                    is_slash;
    logic                    is_minus;
    logic                    is_plus;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [W-1:0]            cur_digit;
    logic                    close_dz;
    logic                    unit_busy;
    logic [W-1:0]            unit_res;
    logic [W-1:0]            term;
    logic [W-1:0]            sum_add;
    logic [RESULT_WIDTH-1:0] sum_ext;
    logic [CHAR_WIDTH-1:0]   digit_full;

    always_comb begin
        is_space   = (char_reg == CH_SPACE);
        is_star    = (char_reg == CH_STAR);
        is_slash   = (char_reg == CH_SLASH);
        is_minus   = (char_reg == CH_MINUS);
        is_plus    = (char_reg == CH_PLUS);
        is_digit   = char_reg inside {[CH_ZERO:CH_NINE]};
        digit_full = char_reg - CH_ZERO;
        digit      = digit_full[3:0];
    end

    // cur * 10 + digit as two shifted adds
    assign cur_digit = {cur_reg[W-4:0], 3'b000} + {cur_reg[W-2:0], 1'b0}
                     + {{(W-4){1'b0}}, digit};

    assign close_dz = (pend_reg == MUL_DIV) && (cur_reg == '0);
    assign term     = (pend_reg == MUL_NONE) ? cur_reg : unit_res;
    assign sum_add  = sign_reg ? (sum_reg - term) : (sum_reg + term);

    generate
        if (W >= RESULT_WIDTH) begin : g_trunc
            assign sum_ext = sum_add[RESULT_WIDTH-1:0];
        end else begin : g_sext
            assign sum_ext = {{(RESULT_WIDTH-W){sum_add[W-1]}}, sum_add};
        end
    endgenerate

    ieval_muldiv #(
        .W (W)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.act == ACT_START),
        .is_div  (pend_reg == MUL_DIV),
        .op_a    (prod_reg),
        .op_b    (cur_reg),
        .busy    (unit_busy),
        .result  (unit_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            prod_reg    <= '0;
            cur_reg     <= '0;
            sign_reg    <= 1'b0;
            pend_reg    <= MUL_NONE;
            stopped_reg <= 1'b0;
            derr_reg    <= 1'b0;
        end else begin
            case (cmd.act)
                ACT_CHAR: begin
                    if (is_digit && !stopped_reg) begin
                        cur_reg <= cur_digit;
                    end else if (!is_space) begin
                        stopped_reg <= 1'b1;
                    end
                end
                ACT_APPLY: begin
                    derr_reg    <= derr_reg | close_dz;
                    cur_reg     <= '0;
                    stopped_reg <= 1'b0;
                    if (is_star || is_slash) begin
                        prod_reg <= term;
                        pend_reg <= is_star ? MUL_MUL : MUL_DIV;
                    end else begin
                        sum_reg  <= sum_add;
                        sign_reg <= is_minus;
                        pend_reg <= MUL_NONE;
                    end
                end
                ACT_FINAL: begin
                    sum_reg     <= '0;
                    prod_reg    <= '0;
                    cur_reg     <= '0;
                    sign_reg    <= 1'b0;
                    pend_reg    <= MUL_NONE;
                    stopped_reg <= 1'b0;
                    derr_reg    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.act == ACT_FINAL) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_char) begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
        if (cmd.act == ACT_FINAL) begin
            out_err_reg   <= derr_reg | close_dz;
            out_value_reg <= (derr_reg | close_dz) ? '0 : sum_ext;
        end
    end

    always_comb begin
        status.is_op     = is_star | is_slash | is_plus | is_minus;
        status.last      = last_reg;
        status.pend_none = (pend_reg == MUL_NONE);
        status.unit_busy = unit_busy;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_err   = out_err_reg;

    a_final_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act == ACT_FINAL) |-> (!out_valid_reg || out_ready))
        else $error("result written over an untaken result");

endmodule

`default_nettype wire

### rtl/ieval_ctrl.sv
// controller state machine: sequences character decode, operator closing and result
// depends on ieval_pkg
`default_nettype none

module ieval_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire ieval_pkg::ieval_status_t  status,
    output ieval_pkg::ieval_cmd_t          cmd
);

    import ieval_pkg::*;

    ieval_state_t state_reg;
    ieval_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load_char = 1'b0;
        cmd.act       = ACT_NONE;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_char = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_op && !status.pend_none) begin
                    cmd.act    = ACT_START;
                    state_next = ST_OPWAIT;
                end else begin
                    cmd.act    = status.is_op ? ACT_APPLY : ACT_CHAR;
                    state_next = status.last ? ST_TAIL : ST_IDLE;
                end
            end
            ST_OPWAIT: begin
                if (!status.unit_busy) begin
                    cmd.act    = ACT_APPLY;
                    state_next = status.last ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (!status.pend_none) begin
                    cmd.act    = ACT_START;
                    state_next = ST_TAILWAIT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_TAILWAIT: begin
                if (!status.unit_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.act    = ACT_FINAL;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted character not decoded next cycle");

endmodule

`default_nettype wire

### tb/tb_infix_integer_expression_eval.sv
// testbench for infix_integer_expression_eval: streams expressions one character per
// transaction, predicts each result in a local evaluator and checks every output field
// depends on ieval_pkg and the rtl top level infix_integer_expression_eval
`timescale 1ns / 1ps

module tb_infix_integer_expression_eval;
    import ieval_pkg::*;

    // one character waiting to be offered on the input channel
    typedef struct {
        logic [CHAR_WIDTH-1:0] ch;
        logic                  last;
        bit                    drain_first; // hold off until every result is back
    } char_item_t;

    // one predicted result transaction
    typedef struct packed {
        logic [RESULT_WIDTH-1:0] value;
        logic                    div_zero;
    } expr_result_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [CHAR_WIDTH-1:0]   s_tdata  = '0;   // [7:0] char_code
    logic                    s_tlast  = 1'b0; // last_char
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [RESULT_WIDTH-1:0] m_tdata;         // [31:0] result_value
    logic                    m_tuser;         // [0] div_zero_error

    char_item_t   char_backlog[$];  // characters not yet accepted by the block
    expr_result_t expr_values[$];   // evaluated expressions not yet seen at the output

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors        = 0;
    int results_seen  = 0;
    int stall_left    = 0;
    bit stall_done    = 0;

    // literals that hit the extremes: max, min after wrap, -1 after wrap, long wrap
    string specials[6] = '{"0", "1", "2147483647", "2147483648", "4294967295",
                           "99999999999"};

    // local copy of the evaluator state
    logic [RESULT_WIDTH-1:0] sum_acc;
    logic [RESULT_WIDTH-1:0] prod_acc;
    logic [RESULT_WIDTH-1:0] num_acc;
    logic                    minus_open;
    logic                    junk_seen;
    logic                    zero_div_seen;
    ieval_mulop_t            mul_waiting;

    infix_integer_expression_eval dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // evaluator
    // ------------------------------------------------------------------

    function automatic void clear_expr();
        sum_acc       = '0;
        prod_acc      = '0;
        num_acc       = '0;
        minus_open    = 1'b0;
        junk_seen     = 1'b0;
        zero_div_seen = 1'b0;
        mul_waiting   = MUL_NONE;
    endfunction

    // signed division toward zero on magnitudes, so min / -1 wraps back to min
    function automatic logic [RESULT_WIDTH-1:0] div_toward_zero(
        logic [RESULT_WIDTH-1:0] a, logic [RESULT_WIDTH-1:0] b);
        logic [RESULT_WIDTH-1:0] mag_a;
        logic [RESULT_WIDTH-1:0] mag_b;
        logic [RESULT_WIDTH-1:0] quot;
        mag_a = a[RESULT_WIDTH-1] ? -a : a;
        mag_b = b[RESULT_WIDTH-1] ? -b : b;
        quot  = mag_a / mag_b;
        return (a[RESULT_WIDTH-1] ^ b[RESULT_WIDTH-1]) ? -quot : quot;
    endfunction

    // finish the open segment against any waiting * or / and return the term
    function automatic logic [RESULT_WIDTH-1:0] close_segment();
        logic [RESULT_WIDTH-1:0] term;
        case (mul_waiting)
            MUL_MUL: begin
                term = prod_acc * num_acc;
            end
            MUL_DIV: begin
                if (num_acc == '0) begin
                    zero_div_seen = 1'b1;
                    term = '0;
                end else begin
                    term = div_toward_zero(prod_acc, num_acc);
                end
            end
            default: begin
                term = num_acc;
            end
        endcase
        num_acc   = '0;
        junk_seen = 1'b0;
        return term;
    endfunction

    function automatic void add_term(logic [RESULT_WIDTH-1:0] term);
        sum_acc = minus_open ? sum_acc - term : sum_acc + term;
    endfunction

    // fold one accepted character in; a last character yields one result
    function automatic void evaluate_char(logic [CHAR_WIDTH-1:0] ch, logic last);
        expr_result_t res;
        if (ch == CH_STAR || ch == CH_SLASH) begin
            prod_acc    = close_segment();
            mul_waiting = (ch == CH_STAR) ? MUL_MUL : MUL_DIV;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            add_term(close_segment());
            minus_open  = (ch == CH_MINUS);
            mul_waiting = MUL_NONE;
        end else if (ch >= CH_ZERO && ch <= CH_NINE && !junk_seen) begin
            num_acc = num_acc * 10 + RESULT_WIDTH'(ch - CH_ZERO);
        end else if (ch != CH_SPACE) begin
            // junk stops the digits of this segment
            junk_seen = 1'b1;
        end
        if (last) begin
            add_term(close_segment());
            res.value    = zero_div_seen ? '0 : sum_acc;
            res.div_zero = zero_div_seen;
            expr_values.push_back(res);
            clear_expr();
        end
    endfunction

    // ------------------------------------------------------------------
    // input driver: offers the head of the backlog, keeps it until accepted
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        char_item_t head;
        logic       offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_expr();
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                evaluate_char(s_tdata, s_tlast);
                void'(char_backlog.pop_front());
                offer = 1'b0;
            end
            if (!offer && char_backlog.size() != 0) begin
                head = char_backlog[0];
                if (!(head.drain_first && expr_values.size() != 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    offer = 1'b1;
                    s_tdata <= head.ch;
                    s_tlast <= head.last;
                end
            end
            s_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // output monitor: checks each result transaction, drives m_tready
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        expr_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expr_values.size() == 0) begin
                    $display("%0t: result with none expected, actual value %0d flag %0b",
                             $time, $signed(m_tdata), m_tuser);
                    errors++;
                end else begin
                    want = expr_values.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t: result_value mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.value), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser !== want.div_zero) begin
                        $display("%0t: div_zero_error mismatch, expected %0b, actual %0b",
                                 $time, want.div_zero, m_tuser);
                        errors++;
                    end
                end
            end
            // one long back-pressure stretch so the block fills and stalls its input
            if (results_seen == 20 && !stall_done) begin
                stall_done = 1'b1;
                stall_left = 600;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic text_bytes(input string s, ref logic [CHAR_WIDTH-1:0] q[$]);
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
    endtask

    // hand one expression to the driver, last flag on its final character
    task automatic queue_expr(ref logic [CHAR_WIDTH-1:0] q[$], input bit drain_first);
        char_item_t it;
        foreach (q[i]) begin
            it.ch          = q[i];
            it.last        = (i == q.size() - 1);
            it.drain_first = drain_first && (i == 0);
            char_backlog.push_back(it);
        end
    endtask

    // mostly well-formed expressions; a few carry junk bytes and empty segments
    task automatic build_random_expr(ref logic [CHAR_WIDTH-1:0] q[$]);
        int terms;
        int pick;
        int n_digits;
        bit noisy;
        terms = $urandom_range(1, 6);
        noisy = ($urandom_range(99) < 15);
        q.delete();
        for (int t = 0; t < terms; t++) begin
            if ($urandom_range(99) < 8) begin
                q.push_back(CH_SPACE);
            end
            pick = $urandom_range(99);
            if (pick < 12) begin
                text_bytes(specials[$urandom_range(5)], q);
            end else if (pick >= 18) begin
                // mostly short operands so products stay meaningful
                n_digits = (pick < 26) ? $urandom_range(5, 11) : $urandom_range(1, 3);
                for (int j = 0; j < n_digits; j++) begin
                    q.push_back(CH_ZERO + CHAR_WIDTH'($urandom_range(9)));
                    if ($urandom_range(99) < 4) begin
                        q.push_back(CH_SPACE);
                    end
                end
            end
            // otherwise an empty segment
            if (noisy && $urandom_range(99) < 35) begin
                q.push_back(CHAR_WIDTH'($urandom));
            end
            if (t < terms - 1 || $urandom_range(99) < 5) begin
                case ($urandom_range(3))
                    0: q.push_back(CH_PLUS);
                    1: q.push_back(CH_MINUS);
                    2: q.push_back(CH_STAR);
                    default: q.push_back(CH_SLASH);
                endcase
            end
        end
        if (q.size() == 0) begin
            q.push_back(CH_ZERO + CHAR_WIDTH'($urandom_range(9)));
        end
    endtask

    task automatic run_random(input int n_chars, input int drain_at);
        logic [CHAR_WIDTH-1:0] q[$];
        int sent;
        int k;
        sent = 0;
        k    = 0;
        while (sent < n_chars) begin
            build_random_expr(q);
            queue_expr(q, k == drain_at);
            sent += q.size();
            k++;
        end
    endtask

    task automatic wait_drained();
        while (char_backlog.size() != 0 || expr_values.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        logic [CHAR_WIDTH-1:0] q[$];

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // phase one: sender idles less than receiver
        send_idle_pct = 19;
        recv_idle_pct = 46;

        // min divided by -1, both reached through digit wrap
        q.delete();
        text_bytes("2147483648/4294967295", q);
        queue_expr(q, 1'b0);
        // zero divisor, evaluation carries on past it
        q.delete();
        text_bytes("7/0+", q);
        queue_expr(q, 1'b0);
        // space inside a number, tab stops the digits, trailing minus, high junk byte
        q.delete();
        text_bytes("1 2*3", q);
        q.push_back(8'h09);
        text_bytes("4-", q);
        q.push_back(8'hFF);
        queue_expr(q, 1'b0);

        // the ninth expression waits for every earlier result to come back
        run_random(600, 8);
        wait_drained();

        // phase two: roles swapped
        send_idle_pct = 46;
        recv_idle_pct = 19;
        run_random(630, -1);
        wait_drained();

        // phase three: full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(630, -1);
        wait_drained();

        // room for any stray result to show up
        repeat (100) @(posedge aclk);

        if (errors == 0) begin
            $display("infix_integer_expression_eval regression: pass");
        end else begin
            $display("infix_integer_expression_eval regression: fail");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #5000000;
        $display("infix_integer_expression_eval regression: fail");
        $finish;
    end

endmodule
